>>> hdl/gswg_pkg.sv
`default_nettype none
package gswg_pkg;

    localparam int AXES      = 3;
    localparam int LANES     = 2 * AXES;
    localparam int DIV_STEPS = 63;

    localparam logic [30:0] ONE_Q30          = 31'h4000_0000;
    localparam logic [30:0] CELL_SPACING_RST = 31'd65536;
    localparam logic [1:0]  DIMENSIONS_RST   = 2'd2;
    localparam logic [1:0]  DIM_3D           = 2'd3;

    localparam logic [0:0]  REG_CELL_SPACING = 1'b0;
    localparam logic [0:0]  REG_DIMENSIONS   = 1'b1;

    localparam logic [31:0] GRAD_MIN = 32'h8000_0000;
    localparam logic [31:0] GRAD_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        RGN_CENTRE,
        RGN_RISE,
        RGN_FALL,
        RGN_LEFT_FLANK,
        RGN_RIGHT_FLANK,
        RGN_NONE
    } region_t;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_ONE_MINUS,
        KIND_CLAMP
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  dneg;
    } axis_tag_t;

    typedef struct packed {
        axis_tag_t [AXES-1:0] ax;
        logic                 three;
    } tag_t;

    // one division: numerator {n_hi, n_lo}, n_hi always below d
    typedef struct packed {
        logic [61:0] n_hi;
        logic [62:0] n_lo;
        logic [61:0] d;
    } lane_t;

    function automatic logic [31:0] grad_sat(logic sat, logic [30:0] mag, logic neg);
        logic [31:0] res;
        if (neg)
        begin
            res = sat ? GRAD_MIN : (32'd0 - {1'b0, mag});
        end
        else
        begin
            res = sat ? GRAD_MAX : {1'b0, mag};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> hdl/gswg_in_if.sv
`default_nettype none
interface gswg_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic        [30:0] half_len_x;
    logic        [30:0] half_len_y;
    logic        [30:0] half_len_z;

    modport source (output valid, offset_x, offset_y, offset_z,
                    half_len_x, half_len_y, half_len_z, input ready);
    modport sink   (input valid, offset_x, offset_y, offset_z,
                    half_len_x, half_len_y, half_len_z, output ready);
endinterface
`default_nettype wire

>>> hdl/gswg_out_if.sv
`default_nettype none
interface gswg_out_if;
    logic               valid;
    logic               ready;
    logic        [30:0] weight;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;

    modport source (output valid, weight, grad_x, grad_y, grad_z, input ready);
    modport sink   (input valid, weight, grad_x, grad_y, grad_z, output ready);
endinterface
`default_nettype wire

>>> hdl/gswg_axis.sv
`default_nettype none
module gswg_axis (
    input  wire logic               clk,
    input  wire logic               adv,
    input  wire logic signed [31:0] offset,
    input  wire logic        [30:0] half_len,
    input  wire logic        [30:0] len,
    output gswg_pkg::lane_t         w_lane,
    output gswg_pkg::lane_t         d_lane,
    output gswg_pkg::axis_tag_t     tag
);

    // stage 1: capture
    logic signed [31:0] x1_reg;
    logic        [30:0] lp1_reg;
    logic        [30:0] len1_reg;

    // stage 2: region, |x|, ramp distance, L*lp
    logic signed [33:0]   xs;
    logic signed [33:0]   lps;
    logic signed [33:0]   lens;
    gswg_pkg::region_t    rgn_next;
    logic        [31:0]   ax_next;
    logic        [32:0]   s_sum;
    logic                 neg_next;
    gswg_pkg::region_t    rgn2_reg;
    logic        [31:0]   ax2_reg;
    logic        [31:0]   s2_reg;
    logic        [61:0]   den2_reg;
    logic        [30:0]   lp2_reg;
    logic        [30:0]   len2_reg;
    logic                 neg2_reg;

    // stage 3: squares
    logic        [31:0]   base;
    gswg_pkg::region_t    rgn3_reg;
    logic        [63:0]   sq3_reg;
    logic        [61:0]   lsq3_reg;
    logic        [31:0]   ax3_reg;
    logic        [31:0]   s3_reg;
    logic        [61:0]   den3_reg;
    logic        [30:0]   len3_reg;
    logic                 neg3_reg;

    // stage 4: numerators and divisor
    logic        [64:0]   sum;
    logic        [91:0]   nw;
    logic        [62:0]   nd;
    logic        [61:0]   dv;
    gswg_pkg::kind_t      kind_next;
    gswg_pkg::lane_t      w_lane_reg;
    gswg_pkg::lane_t      d_lane_reg;
    gswg_pkg::axis_tag_t  tag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg   <= offset;
            lp1_reg  <= (half_len == 31'd0) ? 31'd1 : half_len;
            len1_reg <= len;
        end
    end

    assign xs      = 34'(x1_reg);
    assign lps     = $signed({3'b000, lp1_reg});
    assign lens    = $signed({3'b000, len1_reg});
    assign ax_next = x1_reg[31] ? $unsigned(32'(-x1_reg)) : $unsigned(x1_reg);
    assign s_sum   = {2'b00, len1_reg} + {2'b00, lp1_reg} - {1'b0, ax_next};

    // first matching region wins
    always_comb
    begin
        if ((-lps < xs) && (xs <= lps))
            rgn_next = gswg_pkg::RGN_CENTRE;
        else if ((-lens - lps < xs) && (xs <= lps - lens))
            rgn_next = gswg_pkg::RGN_RISE;
        else if ((lens - lps < xs) && (xs <= lens + lps))
            rgn_next = gswg_pkg::RGN_FALL;
        else if ((lps - lens < xs) && (xs <= -lps))
            rgn_next = gswg_pkg::RGN_LEFT_FLANK;
        else if ((lps < xs) && (xs <= lens - lps))
            rgn_next = gswg_pkg::RGN_RIGHT_FLANK;
        else
            rgn_next = gswg_pkg::RGN_NONE;
    end

    always_comb
    begin
        case (rgn_next)
            gswg_pkg::RGN_CENTRE:      neg_next = !x1_reg[31] && (x1_reg != 32'sd0);
            gswg_pkg::RGN_FALL:        neg_next = 1'b1;
            gswg_pkg::RGN_RIGHT_FLANK: neg_next = 1'b1;
            default:                   neg_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rgn2_reg <= rgn_next;
            ax2_reg  <= ax_next;
            s2_reg   <= s_sum[31:0];
            den2_reg <= len1_reg * lp1_reg;
            lp2_reg  <= lp1_reg;
            len2_reg <= len1_reg;
            neg2_reg <= neg_next;
        end
    end

    assign base = (rgn2_reg == gswg_pkg::RGN_CENTRE) ? ax2_reg : s2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rgn3_reg <= rgn2_reg;
            sq3_reg  <= base * base;
            lsq3_reg <= lp2_reg * lp2_reg;
            ax3_reg  <= ax2_reg;
            s3_reg   <= s2_reg;
            den3_reg <= den2_reg;
            len3_reg <= len2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    assign sum = {1'b0, sq3_reg} + {3'b000, lsq3_reg};

    always_comb
    begin
        case (rgn3_reg)
            gswg_pkg::RGN_CENTRE:
            begin
                nw        = 92'(sum) << 29;
                nd        = 63'(ax3_reg) << 32;
                dv        = den3_reg;
                kind_next = gswg_pkg::KIND_ONE_MINUS;
            end
            gswg_pkg::RGN_RISE, gswg_pkg::RGN_FALL:
            begin
                nw        = 92'(sq3_reg) << 28;
                nd        = 63'(s3_reg) << 31;
                dv        = den3_reg;
                kind_next = gswg_pkg::KIND_CLAMP;
            end
            gswg_pkg::RGN_LEFT_FLANK, gswg_pkg::RGN_RIGHT_FLANK:
            begin
                nw        = 92'(ax3_reg) << 30;
                nd        = 63'(1) << 32;
                dv        = {31'd0, len3_reg};
                kind_next = gswg_pkg::KIND_ONE_MINUS;
            end
            default:
            begin
                nw        = '0;
                nd        = '0;
                dv        = {31'd0, len3_reg};
                kind_next = gswg_pkg::KIND_ZERO;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_lane_reg.n_hi <= 62'(nw[91:63]);
            w_lane_reg.n_lo <= nw[62:0];
            w_lane_reg.d    <= dv;
            d_lane_reg.n_hi <= '0;
            d_lane_reg.n_lo <= nd;
            d_lane_reg.d    <= dv;
            tag_reg.kind    <= kind_next;
            tag_reg.dneg    <= neg3_reg;
        end
    end

    assign w_lane = w_lane_reg;
    assign d_lane = d_lane_reg;
    assign tag    = tag_reg;

endmodule
`default_nettype wire

>>> hdl/gswg_div.sv
`default_nettype none
module gswg_div (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     adv,
    input  wire logic                                     in_vld,
    input  wire gswg_pkg::tag_t                           in_tag,
    input  wire gswg_pkg::lane_t [gswg_pkg::LANES-1:0]    in_lane,
    output logic                                          out_vld,
    output gswg_pkg::tag_t                                out_tag,
    output logic [gswg_pkg::LANES-1:0][62:0]              out_q
);

    logic [gswg_pkg::LANES-1:0][61:0] r_reg   [gswg_pkg::DIV_STEPS];
    logic [gswg_pkg::LANES-1:0][62:0] nq_reg  [gswg_pkg::DIV_STEPS];
    logic [gswg_pkg::LANES-1:0][61:0] d_reg   [gswg_pkg::DIV_STEPS];
    logic                             v_reg   [gswg_pkg::DIV_STEPS];
    gswg_pkg::tag_t                   tag_reg [gswg_pkg::DIV_STEPS];

    genvar g;
    generate
        for (g = 0; g < gswg_pkg::DIV_STEPS; g++)
        begin : g_step
            logic [gswg_pkg::LANES-1:0][61:0] r_src;
            logic [gswg_pkg::LANES-1:0][61:0] d_src;
            logic [gswg_pkg::LANES-1:0][61:0] r_next;
            logic [gswg_pkg::LANES-1:0][62:0] nq_src;
            logic [gswg_pkg::LANES-1:0][62:0] nq_next;
            logic [gswg_pkg::LANES-1:0][62:0] trial;
            logic [gswg_pkg::LANES-1:0][62:0] diff;
            logic                             v_src;
            gswg_pkg::tag_t                   tag_src;

            if (g == 0)
            begin : g_first
                always_comb
                begin
                    for (int l = 0; l < gswg_pkg::LANES; l++)
                    begin
                        r_src[l]  = in_lane[l].n_hi;
                        nq_src[l] = in_lane[l].n_lo;
                        d_src[l]  = in_lane[l].d;
                    end
                end
                assign v_src   = in_vld;
                assign tag_src = in_tag;
            end
            else
            begin : g_rest
                assign r_src   = r_reg[g-1];
                assign nq_src  = nq_reg[g-1];
                assign d_src   = d_reg[g-1];
                assign v_src   = v_reg[g-1];
                assign tag_src = tag_reg[g-1];
            end

            // one restoring step: shift in the next numerator bit, subtract if it fits
            always_comb
            begin
                for (int l = 0; l < gswg_pkg::LANES; l++)
                begin
                    trial[l] = {r_src[l], nq_src[l][62]};
                    diff[l]  = trial[l] - {1'b0, d_src[l]};
                    if (trial[l] >= {1'b0, d_src[l]})
                    begin
                        r_next[l]  = diff[l][61:0];
                        nq_next[l] = {nq_src[l][61:0], 1'b1};
                    end
                    else
                    begin
                        r_next[l]  = trial[l][61:0];
                        nq_next[l] = {nq_src[l][61:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[g] <= 1'b0;
                else if (adv)
                    v_reg[g] <= v_src;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r_reg[g]   <= r_next;
                    nq_reg[g]  <= nq_next;
                    d_reg[g]   <= d_src;
                    tag_reg[g] <= tag_src;
                end
            end
        end
    endgenerate

    assign out_vld = v_reg[gswg_pkg::DIV_STEPS-1];
    assign out_tag = tag_reg[gswg_pkg::DIV_STEPS-1];
    assign out_q   = nq_reg[gswg_pkg::DIV_STEPS-1];

endmodule
`default_nettype wire

>>> hdl/gswg_mul60.sv
`default_nettype none
module gswg_mul60 (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic [62:0] a,
    input  wire logic [60:0] b,
    output logic             sat,
    output logic [30:0]      mag
);

    // (a*b) >> 60 from four partial products, with overflow past 31 bits flagged
    logic [61:0]  hh_reg;
    logic [60:0]  hl_reg;
    logic [62:0]  lh_reg;
    logic [61:0]  ll_reg;
    logic [93:0]  slo_reg;
    logic [93:0]  shi_reg;
    logic [123:0] total;
    logic         sat_reg;
    logic [30:0]  mag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hh_reg <= a[62:32] * b[60:30];
            hl_reg <= a[62:32] * b[29:0];
            lh_reg <= a[31:0] * b[60:30];
            ll_reg <= a[31:0] * b[29:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slo_reg <= {1'b0, hl_reg, 32'd0} + {32'd0, ll_reg};
            shi_reg <= {hh_reg, 32'd0} + {31'd0, lh_reg};
        end
    end

    assign total = {shi_reg, 30'd0} + {30'd0, slo_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_reg <= |total[123:91];
            mag_reg <= total[90:60];
        end
    end

    assign sat = sat_reg;
    assign mag = mag_reg;

endmodule
`default_nettype wire

>>> hdl/gswg_comb.sv
`default_nettype none
module gswg_comb (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  wire logic                              in_vld,
    input  wire gswg_pkg::tag_t                    in_tag,
    input  wire logic [gswg_pkg::LANES-1:0][62:0]  in_q,
    output logic                                   out_vld,
    output logic [30:0]                            weight,
    output logic [31:0]                            grad_x,
    output logic [31:0]                            grad_y,
    output logic [31:0]                            grad_z
);

    logic [gswg_pkg::AXES-1:0][30:0] w_next;
    logic [gswg_pkg::AXES-1:0][62:0] d_next;
    logic [62:0]                     qw;

    logic [gswg_pkg::AXES-1:0][30:0] w1_reg;
    logic [gswg_pkg::AXES-1:0][62:0] d1_reg;
    logic [gswg_pkg::AXES-1:0]       neg1_reg;
    logic                            three1_reg;
    logic                            v1_reg;

    logic [61:0]                     p01_reg;
    logic [61:0]                     p02_reg;
    logic [61:0]                     p12_reg;
    logic [30:0]                     w2c_reg;
    logic [gswg_pkg::AXES-1:0][62:0] d2_reg;
    logic [gswg_pkg::AXES-1:0]       neg2_reg;
    logic                            three2_reg;
    logic                            v2_reg;

    logic                            pv_reg     [3];
    logic [gswg_pkg::AXES-1:0]       pneg_reg   [3];
    logic                            pthree_reg [3];

    logic        ws;
    logic        xs;
    logic        ys;
    logic        zs;
    logic [30:0] wm;
    logic [30:0] xm;
    logic [30:0] ym;
    logic [30:0] zm;

    logic        out_vld_reg;
    logic [30:0] weight_reg;
    logic [31:0] grad_x_reg;
    logic [31:0] grad_y_reg;
    logic [31:0] grad_z_reg;

    // per-axis weight and derivative magnitude from the quotients
    always_comb
    begin
        qw = '0;
        for (int k = 0; k < gswg_pkg::AXES; k++)
        begin
            qw = in_q[2*k];
            case (in_tag.ax[k].kind)
                gswg_pkg::KIND_ONE_MINUS:
                begin
                    w_next[k] = (qw >= 63'(gswg_pkg::ONE_Q30)) ? 31'd0
                              : (gswg_pkg::ONE_Q30 - qw[30:0]);
                    d_next[k] = in_q[2*k+1];
                end
                gswg_pkg::KIND_CLAMP:
                begin
                    w_next[k] = (qw > 63'(gswg_pkg::ONE_Q30)) ? gswg_pkg::ONE_Q30 : qw[30:0];
                    d_next[k] = in_q[2*k+1];
                end
                default:
                begin
                    w_next[k] = '0;
                    d_next[k] = '0;
                end
            endcase
            // planar case: z contributes a unit weight and no slope
            if ((k == gswg_pkg::AXES - 1) && !in_tag.three)
            begin
                w_next[k] = gswg_pkg::ONE_Q30;
                d_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_reg     <= w_next;
            d1_reg     <= d_next;
            three1_reg <= in_tag.three;
            for (int k = 0; k < gswg_pkg::AXES; k++)
            begin
                neg1_reg[k] <= in_tag.ax[k].dneg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p01_reg    <= w1_reg[0] * w1_reg[1];
            p02_reg    <= w1_reg[0] * w1_reg[2];
            p12_reg    <= w1_reg[1] * w1_reg[2];
            w2c_reg    <= w1_reg[2];
            d2_reg     <= d1_reg;
            neg2_reg   <= neg1_reg;
            three2_reg <= three1_reg;
        end
    end

    gswg_mul60 u_mul_w (
        .clk (clk),
        .adv (adv),
        .a   (63'(p01_reg)),
        .b   (61'(w2c_reg)),
        .sat (ws),
        .mag (wm)
    );

    gswg_mul60 u_mul_x (
        .clk (clk),
        .adv (adv),
        .a   (d2_reg[0]),
        .b   (61'(p12_reg)),
        .sat (xs),
        .mag (xm)
    );

    gswg_mul60 u_mul_y (
        .clk (clk),
        .adv (adv),
        .a   (d2_reg[1]),
        .b   (61'(p02_reg)),
        .sat (ys),
        .mag (ym)
    );

    gswg_mul60 u_mul_z (
        .clk (clk),
        .adv (adv),
        .a   (d2_reg[2]),
        .b   (61'(p01_reg)),
        .sat (zs),
        .mag (zm)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pneg_reg[0]   <= neg2_reg;
            pthree_reg[0] <= three2_reg;
            pneg_reg[1]   <= pneg_reg[0];
            pthree_reg[1] <= pthree_reg[0];
            pneg_reg[2]   <= pneg_reg[1];
            pthree_reg[2] <= pthree_reg[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            pv_reg[0]   <= 1'b0;
            pv_reg[1]   <= 1'b0;
            pv_reg[2]   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg      <= in_vld;
            v2_reg      <= v1_reg;
            pv_reg[0]   <= v2_reg;
            pv_reg[1]   <= pv_reg[0];
            pv_reg[2]   <= pv_reg[1];
            out_vld_reg <= pv_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            weight_reg <= ws ? gswg_pkg::ONE_Q30 : wm;
            grad_x_reg <= gswg_pkg::grad_sat(xs, xm, pneg_reg[2][0]);
            grad_y_reg <= gswg_pkg::grad_sat(ys, ym, pneg_reg[2][1]);
            grad_z_reg <= pthree_reg[2] ? gswg_pkg::grad_sat(zs, zm, pneg_reg[2][2]) : 32'd0;
        end
    end

    assign out_vld = out_vld_reg;
    assign weight  = weight_reg;
    assign grad_x  = grad_x_reg;
    assign grad_y  = grad_y_reg;
    assign grad_z  = grad_z_reg;

endmodule
`default_nettype wire

>>> hdl/gimp_shape_weight_gradient.sv
// Uniform GIMP shape weight and gradient, one particle-node pair per beat.
// Pipeline: 4 front stages, 63 restoring divider stages, 5 product stages and the output register.
// Throughput: one beat per cycle; the whole pipeline holds only while the output is stalled.
// Reset: rst_n clears all valid bits and sets spacing to 65536 and dimensions to 2.
`default_nettype none
module gimp_shape_weight_gradient (
    input  wire logic        clk,
    input  wire logic        rst_n,
    gswg_in_if.sink          pair,
    gswg_out_if.source       shape,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);

    logic [30:0] cell_spacing_reg;
    logic [1:0]  dimensions_reg;
    logic [30:0] len;
    logic        adv;
    logic        out_vld;

    logic        fv_reg [4];
    logic        tf_reg [4];

    gswg_pkg::lane_t [gswg_pkg::LANES-1:0]  lanes;
    gswg_pkg::axis_tag_t [gswg_pkg::AXES-1:0] atags;
    gswg_pkg::tag_t                         div_tag;
    logic                                   div_vld;
    gswg_pkg::tag_t                         q_tag;
    logic                                   q_vld;
    logic [gswg_pkg::LANES-1:0][62:0]       q;
    logic [31:0]                            gx;
    logic [31:0]                            gy;
    logic [31:0]                            gz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_spacing_reg <= gswg_pkg::CELL_SPACING_RST;
            dimensions_reg   <= gswg_pkg::DIMENSIONS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gswg_pkg::REG_CELL_SPACING: cell_spacing_reg <= cfg_data;
                gswg_pkg::REG_DIMENSIONS:   dimensions_reg   <= cfg_data[1:0];
                default:                    ;
            endcase
        end
    end

    assign len = (cell_spacing_reg == 31'd0) ? 31'd1 : cell_spacing_reg;

    // hold everything while a finished beat waits at the output
    assign adv        = !out_vld || shape.ready;
    assign pair.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg[0] <= 1'b0;
            fv_reg[1] <= 1'b0;
            fv_reg[2] <= 1'b0;
            fv_reg[3] <= 1'b0;
        end
        else if (adv)
        begin
            fv_reg[0] <= pair.valid;
            fv_reg[1] <= fv_reg[0];
            fv_reg[2] <= fv_reg[1];
            fv_reg[3] <= fv_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tf_reg[0] <= (dimensions_reg == gswg_pkg::DIM_3D);
            tf_reg[1] <= tf_reg[0];
            tf_reg[2] <= tf_reg[1];
            tf_reg[3] <= tf_reg[2];
        end
    end

    gswg_axis u_axis_x (
        .clk      (clk),
        .adv      (adv),
        .offset   (pair.offset_x),
        .half_len (pair.half_len_x),
        .len      (len),
        .w_lane   (lanes[0]),
        .d_lane   (lanes[1]),
        .tag      (atags[0])
    );

    gswg_axis u_axis_y (
        .clk      (clk),
        .adv      (adv),
        .offset   (pair.offset_y),
        .half_len (pair.half_len_y),
        .len      (len),
        .w_lane   (lanes[2]),
        .d_lane   (lanes[3]),
        .tag      (atags[1])
    );

    gswg_axis u_axis_z (
        .clk      (clk),
        .adv      (adv),
        .offset   (pair.offset_z),
        .half_len (pair.half_len_z),
        .len      (len),
        .w_lane   (lanes[4]),
        .d_lane   (lanes[5]),
        .tag      (atags[2])
    );

    assign div_tag.ax    = atags;
    assign div_tag.three = tf_reg[3];
    assign div_vld       = fv_reg[3];

    gswg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (div_vld),
        .in_tag  (div_tag),
        .in_lane (lanes),
        .out_vld (q_vld),
        .out_tag (q_tag),
        .out_q   (q)
    );

    gswg_comb u_comb (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (q_vld),
        .in_tag  (q_tag),
        .in_q    (q),
        .out_vld (out_vld),
        .weight  (shape.weight),
        .grad_x  (gx),
        .grad_y  (gy),
        .grad_z  (gz)
    );

    assign shape.valid  = out_vld;
    assign shape.grad_x = $signed(gx);
    assign shape.grad_y = $signed(gy);
    assign shape.grad_z = $signed(gz);

endmodule
`default_nettype wire
